[sv/bfc_pkg.sv]
package bfc_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W         = CNT_W + 7;

    localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
    localparam logic        KIND_COUNT     = 1'b0;
    localparam logic        KIND_READ      = 1'b1;
    localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MISS,
        ST_READ,
        ST_SKIP
    } bfc_state_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] count;
    } bfc_entry_t;

    typedef struct packed {
        logic             en;
        logic             all;
        logic [IDX_W-1:0] idx;
        bfc_entry_t       data;
    } bfc_wr_t;

    typedef struct packed {
        logic        is_ip;
        logic        matched;
        logic        inserted;
        logic        dropped_full;
        logic        entry_valid;
        logic [6:0]  entry_index;
        logic [31:0] entry_count;
        logic [31:0] entry_src;
        logic [31:0] entry_dst;
        logic [7:0]  entries_used;
        logic [31:0] ip_packet_total;
    } bfc_res_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

[sv/bfc_if.sv]
interface bfc_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] frame_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [6:0]  read_index;

    modport source (output valid, kind, frame_type, src_addr, dst_addr, read_index,
                    input ready);
    modport sink   (input valid, kind, frame_type, src_addr, dst_addr, read_index,
                    output ready);
endinterface

interface bfc_out_if;
    logic        valid;
    logic        ready;
    logic        is_ip;
    logic        matched;
    logic        inserted;
    logic        dropped_full;
    logic        entry_valid;
    logic [6:0]  entry_index;
    logic [31:0] entry_count;
    logic [31:0] entry_src;
    logic [31:0] entry_dst;
    logic [7:0]  entries_used;
    logic [31:0] ip_packet_total;

    modport source (output valid, is_ip, matched, inserted, dropped_full, entry_valid,
                    entry_index, entry_count, entry_src, entry_dst, entries_used,
                    ip_packet_total,
                    input ready);
    modport sink   (input valid, is_ip, matched, inserted, dropped_full, entry_valid,
                    entry_index, entry_count, entry_src, entry_dst, entries_used,
                    ip_packet_total,
                    output ready);
endinterface

[sv/bidirectional_flow_counter.sv]
// Bidirectional conversation counter. Each request beat is either a packet
// header to count or a read of one stored conversation. Headers whose
// ethertype is not IPv4 pass untouched. An IPv4 header bumps a saturating
// packet total and then scans the conversation table, one entry per cycle
// through a synchronous memory, for an address pair that matches in either
// direction; a hit bumps that entry's saturating count, a miss appends a new
// entry with count one, or flags the packet as dropped when the table is full.
// Every request yields exactly one response beat. An IPv4 header that misses
// walks every used entry through the single memory read port, and one that
// hits stops at the matching entry; any response then waits for the response
// slot. One request is in flight at a time; the next request beat is taken
// once the current one has its response registered, even while that
// response still waits for the sink. The table has no reset: only entries
// below the used count are ever read.
module bidirectional_flow_counter (
    input  logic        clk,
    input  logic        rst_n,
    bfc_in_if.sink      req,
    bfc_out_if.source   rsp
);
    import bfc_pkg::*;

    bfc_state_t       state_reg, state_next;

    // Held request payload
    logic [31:0]      src_reg, src_next;
    logic [31:0]      dst_reg, dst_next;
    logic [6:0]       ridx_reg, ridx_next;
    logic             rd_ok_reg, rd_ok_next;

    // Scan pipeline: issue pointer and the entry whose data is on the read port
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;

    logic [CNT_W-1:0] used_reg, used_next;
    logic [31:0]      ip_total_reg, ip_total_next;

    logic             out_vld_reg, out_vld_next;
    bfc_res_t         res_reg, res_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    bfc_entry_t       rd_data;
    bfc_wr_t          wr;

    logic             out_free;
    logic             pair_hit;
    logic             read_in_range;

    bfc_pair_mem u_mem (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    assign out_free = !out_vld_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);

    assign pair_hit = cmp_vld_reg &&
                      ((rd_data.src == src_reg && rd_data.dst == dst_reg) ||
                       (rd_data.src == dst_reg && rd_data.dst == src_reg));

    assign read_in_range = (CMP_W'(req.read_index) < CMP_W'(used_reg)) &&
                           (CMP_W'(req.read_index) < CMP_W'(TABLE_ENTRIES));

    always_comb
    begin
        state_next    = state_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        ridx_next     = ridx_reg;
        rd_ok_next    = rd_ok_reg;
        issue_next    = issue_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        used_next     = used_reg;
        ip_total_next = ip_total_reg;
        res_next      = res_reg;
        out_vld_next  = out_vld_reg && !rsp.ready;
        rd_en         = 1'b0;
        rd_idx        = issue_reg[IDX_W-1:0];
        wr            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    src_next  = req.src_addr;
                    dst_next  = req.dst_addr;
                    ridx_next = req.read_index;
                    if (req.kind == KIND_READ)
                    begin
                        // Fetch the entry now; data is there next cycle
                        rd_ok_next = read_in_range;
                        rd_en      = read_in_range;
                        rd_idx     = IDX_W'(req.read_index);
                        state_next = ST_READ;
                    end
                    else if (req.frame_type == IPV4_ETHERTYPE)
                    begin
                        ip_total_next = sat_inc(ip_total_reg);
                        issue_next    = '0;
                        cmp_vld_next  = 1'b0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_SKIP;
                    end
                end
            end

            ST_SCAN:
            begin
                // Compare the entry fetched last cycle while fetching the next
                if (pair_hit)
                begin
                    cmp_vld_next = 1'b0;
                    state_next   = ST_HIT;
                end
                else if (issue_reg < used_reg)
                begin
                    rd_en        = 1'b1;
                    rd_idx       = issue_reg[IDX_W-1:0];
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[IDX_W-1:0];
                    issue_next   = issue_reg + CNT_W'(1);
                end
                else
                begin
                    // Drain the last compare, then give up
                    cmp_vld_next = 1'b0;
                    if (!cmp_vld_reg)
                    begin
                        state_next = ST_MISS;
                    end
                end
            end

            ST_HIT:
            begin
                if (out_free)
                begin
                    wr.en         = 1'b1;
                    wr.all        = 1'b0;
                    wr.idx        = cmp_idx_reg;
                    wr.data.src   = rd_data.src;
                    wr.data.dst   = rd_data.dst;
                    wr.data.count = sat_inc(rd_data.count);

                    res_next                 = '0;
                    res_next.is_ip           = 1'b1;
                    res_next.matched         = 1'b1;
                    res_next.entry_valid     = 1'b1;
                    res_next.entry_index     = 7'(cmp_idx_reg);
                    res_next.entry_count     = sat_inc(rd_data.count);
                    res_next.entry_src       = rd_data.src;
                    res_next.entry_dst       = rd_data.dst;
                    res_next.entries_used    = 8'(used_reg);
                    res_next.ip_packet_total = ip_total_reg;
                    out_vld_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            ST_MISS:
            begin
                if (out_free)
                begin
                    res_next                 = '0;
                    res_next.is_ip           = 1'b1;
                    res_next.ip_packet_total = ip_total_reg;
                    if (used_reg < CNT_W'(TABLE_ENTRIES))
                    begin
                        // Append at the end of the table
                        wr.en         = 1'b1;
                        wr.all        = 1'b1;
                        wr.idx        = used_reg[IDX_W-1:0];
                        wr.data.src   = src_reg;
                        wr.data.dst   = dst_reg;
                        wr.data.count = 32'd1;
                        used_next     = used_reg + CNT_W'(1);

                        res_next.inserted     = 1'b1;
                        res_next.entry_valid  = 1'b1;
                        res_next.entry_index  = 7'(used_reg);
                        res_next.entry_count  = 32'd1;
                        res_next.entry_src    = src_reg;
                        res_next.entry_dst    = dst_reg;
                        res_next.entries_used = 8'(used_reg + CNT_W'(1));
                    end
                    else
                    begin
                        res_next.dropped_full = 1'b1;
                        res_next.entries_used = 8'(used_reg);
                    end
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            ST_READ:
            begin
                if (out_free)
                begin
                    res_next                 = '0;
                    res_next.entry_valid     = rd_ok_reg;
                    res_next.entry_index     = ridx_reg;
                    if (rd_ok_reg)
                    begin
                        res_next.entry_count = rd_data.count;
                        res_next.entry_src   = rd_data.src;
                        res_next.entry_dst   = rd_data.dst;
                    end
                    res_next.entries_used    = 8'(used_reg);
                    res_next.ip_packet_total = ip_total_reg;
                    out_vld_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            ST_SKIP:
            begin
                if (out_free)
                begin
                    res_next                 = '0;
                    res_next.entries_used    = 8'(used_reg);
                    res_next.ip_packet_total = ip_total_reg;
                    out_vld_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_ok_reg    <= 1'b0;
            issue_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            used_reg     <= '0;
            ip_total_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_ok_reg    <= rd_ok_next;
            issue_reg    <= issue_next;
            cmp_vld_reg  <= cmp_vld_next;
            used_reg     <= used_next;
            ip_total_reg <= ip_total_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        ridx_reg    <= ridx_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    assign rsp.valid           = out_vld_reg;
    assign rsp.is_ip           = res_reg.is_ip;
    assign rsp.matched         = res_reg.matched;
    assign rsp.inserted        = res_reg.inserted;
    assign rsp.dropped_full    = res_reg.dropped_full;
    assign rsp.entry_valid     = res_reg.entry_valid;
    assign rsp.entry_index     = res_reg.entry_index;
    assign rsp.entry_count     = res_reg.entry_count;
    assign rsp.entry_src       = res_reg.entry_src;
    assign rsp.entry_dst       = res_reg.entry_dst;
    assign rsp.entries_used    = res_reg.entries_used;
    assign rsp.ip_packet_total = res_reg.ip_packet_total;

endmodule

[sv/bfc_pair_mem.sv]
module bfc_pair_mem (
    input  logic                     clk,
    input  bfc_pkg::bfc_wr_t         wr,
    input  logic                     rd_en,
    input  logic [bfc_pkg::IDX_W-1:0] rd_idx,
    output bfc_pkg::bfc_entry_t      rd_data
);
    import bfc_pkg::*;

    logic [31:0] src_mem [TABLE_ENTRIES];
    logic [31:0] dst_mem [TABLE_ENTRIES];
    logic [31:0] cnt_mem [TABLE_ENTRIES];
    bfc_entry_t  rd_data_reg;

    // Count always written; addresses only on a new entry
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            cnt_mem[wr.idx] <= wr.data.count;
            if (wr.all)
            begin
                src_mem[wr.idx] <= wr.data.src;
                dst_mem[wr.idx] <= wr.data.dst;
            end
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg.src   <= src_mem[rd_idx];
            rd_data_reg.dst   <= dst_mem[rd_idx];
            rd_data_reg.count <= cnt_mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
